// File: rtl/wsp_pkg.sv
// Package for the weighted 2x2 subsampling pool: item kinds, register
// indexes, arithmetic constants and the records passed between the blocks.
// No dependencies.
package wsp_pkg;

  localparam int DATA_W      = 16;  // sample, weight, bias and result width
  localparam int IDX_W       = 6;   // table_index field width
  localparam int POS_W       = 4;   // out_channel / out_row / out_col width
  localparam int MAP_REG_W   = 6;   // map_width register width
  localparam int CHAN_REG_W  = 5;   // channels_in_use register width
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 6;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int ACC_W       = 34;  // exact Q10.24 window sum
  localparam int SCALED_W    = 48;  // window sum times the Q2.12 scale
  localparam int WADDR_MAX_W = 8;   // weight address at the largest channel count
  localparam int BADDR_MAX_W = 6;   // bias address at the largest channel count
  localparam int SLOT_MAX_W  = 5;   // upper-row slot at the largest map width

  // 2.7 in Q2.12, and the half LSB used to round Q.36 down to Q.12.
  localparam logic signed [14:0] SCALE_Q12  = 15'sd11059;
  localparam logic signed [SCALED_W-1:0] ROUND_HALF = 48'sd8388608;
  localparam int ROUND_SHIFT = 24;

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_WEIGHT = 2'd1,
    FUNC_BIAS   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS  = 1'd1;

  typedef struct packed {
    logic                  en;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // One classified item on its way from the front end to the back end.
  typedef struct packed {
    func_t                  kind;
    logic [DATA_W-1:0]      value;
    logic [WADDR_MAX_W-1:0] waddr;
    logic [BADDR_MAX_W-1:0] baddr;
    logic [SLOT_MAX_W-1:0]  slot;
    logic                   col_odd;
    logic                   row_odd;
    logic [POS_W-1:0]       ochan;
    logic [POS_W-1:0]       orow;
    logic [POS_W-1:0]       ocol;
    logic                   last;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] pooled;
    logic [POS_W-1:0]  chan;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic              done;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_ACC,
    BK_SCALE,
    BK_FINISH
  } back_state_t;

endpackage

// File: rtl/wsp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module wsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/wsp_queue.sv
// Short FIFO of classified items between the front end and the back end.
// Depends on wsp_pkg.
module wsp_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  wsp_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output wsp_pkg::cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wsp_pkg::cmd_t    entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = entries_r[rd_ptr_r];

endmodule

// File: rtl/wsp_front.sv
// Front end: configuration registers, raster position counters and the
// classification of each accepted item into a queue entry. Depends on wsp_pkg.
module wsp_front #(
  parameter int MAX_MAP_WIDTH = 32,
  parameter int MAX_CHANNELS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  wsp_pkg::cfg_wr_t             cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_func,
  input  logic [wsp_pkg::DATA_W-1:0]   in_value,
  input  logic [wsp_pkg::IDX_W-1:0]    in_index,
  input  logic                         q_full,
  output logic                         q_push,
  output wsp_pkg::cmd_t                q_cmd
);

  localparam int CNT_W = $clog2(MAX_MAP_WIDTH);
  localparam int EW_W  = $clog2(MAX_MAP_WIDTH + 1);
  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int EC_W  = $clog2(MAX_CHANNELS + 1);

  logic [wsp_pkg::MAP_REG_W-1:0]  map_width_r;
  logic [wsp_pkg::CHAN_REG_W-1:0] channels_r;
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [CH_W-1:0]  ch_r, ch_nxt;

  logic [6:0]      w_raw, w_clamp, c_raw, c_clamp;
  logic [EW_W-1:0] eff_w;
  logic [EC_W-1:0] eff_ch;
  logic            col_wrap, row_wrap, ch_wrap;
  logic            accept, keep;
  wsp_pkg::func_t  kind;

  // Effective map side: even, at least 2, at most the built maximum.
  always_comb begin
    w_raw = {1'b0, map_width_r[wsp_pkg::MAP_REG_W-1:1], 1'b0};
    if (w_raw < 7'd2) begin
      w_clamp = 7'd2;
    end else if (w_raw > 7'(MAX_MAP_WIDTH)) begin
      w_clamp = 7'(MAX_MAP_WIDTH);
    end else begin
      w_clamp = w_raw;
    end
    c_raw = {2'b00, channels_r};
    if (c_raw == 7'd0) begin
      c_clamp = 7'd1;
    end else if (c_raw > 7'(MAX_CHANNELS)) begin
      c_clamp = 7'(MAX_CHANNELS);
    end else begin
      c_clamp = c_raw;
    end
    eff_w  = w_clamp[EW_W-1:0];
    eff_ch = c_clamp[EC_W-1:0];
  end

  assign col_wrap = ((CNT_W + 1)'(col_r) + 1'b1) >= (CNT_W + 1)'(eff_w);
  assign row_wrap = ((CNT_W + 1)'(row_r) + 1'b1) >= (CNT_W + 1)'(eff_w);
  assign ch_wrap  = ((CH_W + 1)'(ch_r) + 1'b1) >= (CH_W + 1)'(eff_ch);

  assign kind     = wsp_pkg::func_t'(in_func);
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    keep = 1'b0;
    case (kind)
      wsp_pkg::FUNC_SAMPLE: keep = 1'b1;
      wsp_pkg::FUNC_WEIGHT: keep = ({3'b000, in_index} < 9'(MAX_CHANNELS * 4));
      wsp_pkg::FUNC_BIAS:   keep = ({1'b0, in_index} < 7'(MAX_CHANNELS));
      default:              keep = 1'b0;
    endcase
  end

  assign q_push = accept && keep;

  always_comb begin
    q_cmd         = '0;
    q_cmd.kind    = kind;
    q_cmd.value   = in_value;
    if (kind == wsp_pkg::FUNC_SAMPLE) begin
      q_cmd.waddr   = wsp_pkg::WADDR_MAX_W'({ch_r, row_r[0], col_r[0]});
      q_cmd.baddr   = wsp_pkg::BADDR_MAX_W'(ch_r);
      q_cmd.slot    = wsp_pkg::SLOT_MAX_W'(col_r >> 1);
      q_cmd.col_odd = col_r[0];
      q_cmd.row_odd = row_r[0];
      q_cmd.ochan   = wsp_pkg::POS_W'(ch_r);
      q_cmd.orow    = wsp_pkg::POS_W'(row_r >> 1);
      q_cmd.ocol    = wsp_pkg::POS_W'(col_r >> 1);
      q_cmd.last    = col_wrap && row_wrap;
    end else begin
      q_cmd.waddr   = wsp_pkg::WADDR_MAX_W'(in_index);
      q_cmd.baddr   = wsp_pkg::BADDR_MAX_W'(in_index);
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    ch_nxt  = ch_r;
    if (accept && kind == wsp_pkg::FUNC_SAMPLE) begin
      if (col_wrap) begin
        col_nxt = '0;
        if (row_wrap) begin
          row_nxt = '0;
          ch_nxt  = ch_wrap ? '0 : ch_r + 1'b1;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r <= wsp_pkg::MAP_REG_W'(28);
      channels_r  <= wsp_pkg::CHAN_REG_W'(6);
      col_r       <= '0;
      row_r       <= '0;
      ch_r        <= '0;
    end else if (cfg.en) begin
      // Any register write restarts at the top of map 0.
      if (cfg.index == wsp_pkg::CFG_MAP_WIDTH) begin
        map_width_r <= cfg.data[wsp_pkg::MAP_REG_W-1:0];
      end else if (cfg.index == wsp_pkg::CFG_CHANNELS) begin
        channels_r <= cfg.data[wsp_pkg::CHAN_REG_W-1:0];
      end
      col_r <= '0;
      row_r <= '0;
      ch_r  <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      ch_r  <= ch_nxt;
    end
  end

endmodule

// File: rtl/wsp_back.sv
// Back end: table writes, multiply-accumulate over each window, scaling,
// bias and saturation, and the result register. Depends on wsp_pkg, wsp_ram.
module wsp_back #(
  parameter int MAX_MAP_WIDTH = 32,
  parameter int MAX_CHANNELS  = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_not_empty,
  input  wsp_pkg::cmd_t    q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output wsp_pkg::result_t out_res
);

  localparam int WDEPTH = MAX_CHANNELS * 4;
  localparam int SDEPTH = MAX_MAP_WIDTH / 2;
  localparam int WAW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int BAW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SAW = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int DW  = wsp_pkg::DATA_W;

  wsp_pkg::back_state_t state_r, state_nxt;
  wsp_pkg::cmd_t        cmd_r, cmd_sel;

  logic                             w_we, b_we, s_we, load_out;
  logic [DW-1:0]                    w_rd, b_rd;
  logic [wsp_pkg::ACC_W-1:0]        s_rd;
  logic signed [wsp_pkg::PROD_W-1:0]   prod_r;
  logic signed [wsp_pkg::ACC_W-1:0]    pair_r, win_r, prod_ext, acc_sum;
  logic signed [wsp_pkg::SCALED_W-1:0] scaled_r, rounded;
  logic signed [23:0]               shifted;
  logic signed [24:0]               biased;
  logic [DW-1:0]                    sat;
  logic                             out_valid_r;
  wsp_pkg::result_t                 out_res_r;

  // Reads are addressed from the queue head while waiting, then held on the
  // item in work so the registered read data stays put.
  assign cmd_sel = (state_r == wsp_pkg::BK_IDLE) ? q_head : cmd_r;

  wsp_ram #(.WIDTH(DW), .DEPTH(WDEPTH)) u_weights (
    .clk   (clk),
    .we    (w_we),
    .waddr (q_head.waddr[WAW-1:0]),
    .wdata (q_head.value),
    .raddr (cmd_sel.waddr[WAW-1:0]),
    .rdata (w_rd)
  );

  wsp_ram #(.WIDTH(DW), .DEPTH(MAX_CHANNELS)) u_biases (
    .clk   (clk),
    .we    (b_we),
    .waddr (q_head.baddr[BAW-1:0]),
    .wdata (q_head.value),
    .raddr (cmd_sel.baddr[BAW-1:0]),
    .rdata (b_rd)
  );

  wsp_ram #(.WIDTH(wsp_pkg::ACC_W), .DEPTH(SDEPTH)) u_row_sums (
    .clk   (clk),
    .we    (s_we),
    .waddr (cmd_r.slot[SAW-1:0]),
    .wdata (acc_sum),
    .raddr (cmd_sel.slot[SAW-1:0]),
    .rdata (s_rd)
  );

  assign prod_ext = {{(wsp_pkg::ACC_W - wsp_pkg::PROD_W){prod_r[wsp_pkg::PROD_W-1]}}, prod_r};
  assign acc_sum  = cmd_r.col_odd ? pair_r + prod_ext : prod_ext;

  // Round Q.36 to Q.12 with a floor shift, add the bias, saturate.
  always_comb begin
    rounded = scaled_r + wsp_pkg::ROUND_HALF;
    shifted = rounded[wsp_pkg::SCALED_W-1:wsp_pkg::ROUND_SHIFT];
    biased  = {shifted[23], shifted} + {{9{b_rd[DW-1]}}, b_rd};
    if (biased > 25'sd32767) begin
      sat = 16'h7FFF;
    end else if (biased < -25'sd32768) begin
      sat = 16'h8000;
    end else begin
      sat = biased[DW-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    w_we      = 1'b0;
    b_we      = 1'b0;
    s_we      = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      wsp_pkg::BK_IDLE: begin
        if (q_not_empty) begin
          q_pop = 1'b1;
          case (q_head.kind)
            wsp_pkg::FUNC_SAMPLE: state_nxt = wsp_pkg::BK_MUL;
            wsp_pkg::FUNC_WEIGHT: w_we = 1'b1;
            wsp_pkg::FUNC_BIAS:   b_we = 1'b1;
            default:              state_nxt = wsp_pkg::BK_IDLE;
          endcase
        end
      end
      wsp_pkg::BK_MUL: state_nxt = wsp_pkg::BK_ACC;
      wsp_pkg::BK_ACC: begin
        if (cmd_r.col_odd && cmd_r.row_odd) begin
          state_nxt = wsp_pkg::BK_SCALE;
        end else begin
          s_we      = cmd_r.col_odd;
          state_nxt = wsp_pkg::BK_IDLE;
        end
      end
      wsp_pkg::BK_SCALE: state_nxt = wsp_pkg::BK_FINISH;
      wsp_pkg::BK_FINISH: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = wsp_pkg::BK_IDLE;
        end
      end
      default: state_nxt = wsp_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wsp_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_head;
    end
    if (state_r == wsp_pkg::BK_MUL) begin
      prod_r <= $signed(cmd_r.value) * $signed(w_rd);
    end
    if (state_r == wsp_pkg::BK_ACC) begin
      pair_r <= acc_sum;
      win_r  <= $signed(s_rd) + acc_sum;
    end
    if (state_r == wsp_pkg::BK_SCALE) begin
      scaled_r <= win_r * wsp_pkg::SCALE_Q12;
    end
    if (load_out) begin
      out_res_r.pooled <= sat;
      out_res_r.chan   <= cmd_r.ochan;
      out_res_r.row    <= cmd_r.orow;
      out_res_r.col    <= cmd_r.ocol;
      out_res_r.done   <= cmd_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// File: rtl/weighted_2x2_subsample_pool.sv
// Top level of the weighted 2x2 subsampling pool: stream ports, front end,
// item queue and back end. Depends on wsp_pkg, wsp_front, wsp_queue, wsp_back.
//
// This block performs trainable 2x2 subsampling. Feature-map samples arrive
// in raster order, one square map after another; every non-overlapping 2x2
// window is weighted by its channel's four weights, summed exactly, scaled by
// 2.7 (Q2.12), rounded to Q4.12, offset by the channel's bias and saturated to
// 16 bits. One result leaves when the bottom-right sample of a window arrives,
// and out_tlast marks the last window of each map. Weights and biases are
// loaded in-band with tuser codes 1 and 2; tuser code 3 is accepted and
// dropped, as are table writes beyond the built channel count. Every read of
// a weight or bias that was never loaded returns an unspecified value, so
// the tables must be loaded before samples are sent. Writing either register
// restarts the stream at row 0, column 0 of map 0; write registers only while
// the block is idle. The back-end sequencer takes one item at a time from a
// two-entry queue and finishes it before taking the next: a table load is
// written from the idle state, a sample that closes no window goes through
// the table read, multiply and accumulate steps, and a sample that closes a
// window adds the scale multiply and the bias/saturation step, in which it
// waits while the output register still holds an untaken result. A finished
// result waits in the output register while the next samples are worked on.
module weighted_2x2_subsample_pool #(
  parameter int MAX_MAP_WIDTH = 32,
  parameter int MAX_CHANNELS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_addr,
  input  logic [5:0]  cfg_data,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] value, [21:16] table_index, [23:22] zero
  input  logic [1:0]  in_tuser,   // [1:0] func
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] pooled_value, [19:16] out_channel,
                                  // [23:20] out_row, [27:24] out_col, [31:28] zero
  output logic        out_tlast   // map_done
);

  wsp_pkg::cfg_wr_t cfg;
  wsp_pkg::cmd_t    push_cmd, head;
  wsp_pkg::result_t res;
  logic             q_push, q_full, q_pop, q_not_empty;

  assign cfg.en    = cfg_wr_en;
  assign cfg.index = cfg_addr;
  assign cfg.data  = cfg_data;

  // The front end keeps the raster position and tags each sample with its
  // table addresses, so the back end never needs the counters.
  wsp_front #(
    .MAX_MAP_WIDTH (MAX_MAP_WIDTH),
    .MAX_CHANNELS  (MAX_CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_func  (in_tuser),
    .in_value (in_tdata[15:0]),
    .in_index (in_tdata[21:16]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  wsp_queue #(.DEPTH(2)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head)
  );

  wsp_back #(
    .MAX_MAP_WIDTH (MAX_MAP_WIDTH),
    .MAX_CHANNELS  (MAX_CHANNELS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (head),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_res     (res)
  );

  assign out_tdata = {4'b0000, res.col, res.row, res.chan, res.pooled};
  assign out_tlast = res.done;

endmodule

// File: rtl/wsp_checker.sv
// Port-level checks for the weighted 2x2 subsampling pool, bound to the top
// level. Depends on weighted_2x2_subsample_pool.
module wsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  // A result that is not taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Reset empties the result register.
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Reset empties the queue, so input is ready right after it.
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  // The map is square, so its last window sits on the diagonal.
  a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[27:24] == out_tdata[23:20])
    else $error("last window of a map is off the diagonal");

endmodule

bind weighted_2x2_subsample_pool wsp_checker u_wsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
